// ===== rtl/lbc_pkg.sv =====
// Package for the LRU block buffer cache: request codes, status codes,
// entry record and response record. No dependencies.
package lbc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 8;

  localparam logic [7:0] COUNT_LIMIT = 8'd255;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_NOBUF = 3'd2;
  localparam logic [2:0] ST_ERROR = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    logic [15:0] dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic        dirty;
    logic        valid;
  } entry_t;

  typedef struct packed {
    logic [2:0] slot_out;
    logic [2:0] status;
    logic       need_disk_read;
    logic       need_disk_write;
  } rsp_t;

endpackage

// ===== rtl/lbc_if.sv =====
// Request and response channel interfaces (valid/ready plus item payload).
// No dependencies.
interface lbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] device;
  logic [31:0] block_number;
  logic [2:0]  slot_in;

  modport source (output valid, output opcode, output device, output block_number,
                  output slot_in, input ready);
  modport sink   (input valid, input opcode, input device, input block_number,
                  input slot_in, output ready);
endinterface

interface lbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot_out;
  logic [2:0] status;
  logic       need_disk_read;
  logic       need_disk_write;

  modport source (output valid, output slot_out, output status, output need_disk_read,
                  output need_disk_write, input ready);
  modport sink   (input valid, input slot_out, input status, input need_disk_read,
                  input need_disk_write, output ready);
endinterface

// ===== rtl/lbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Same-address read during write returns the old word. No dependencies.
module lbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/lbc_seq.sv =====
// Sequencer and shared tag compare unit of the buffer cache, with the entry
// and recency-order RAMs. Depends on lbc_pkg, lbc_if, lbc_ram.
module lbc_seq #(
  parameter int unsigned ENTRIES = lbc_pkg::ENTRIES_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbc_req_if.sink       req_i,
  output logic          rsp_valid_o,
  output lbc_pkg::rsp_t rsp_o,
  input  logic          rsp_take_i
);
  localparam int unsigned SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EW = $bits(lbc_pkg::entry_t);
  localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_FIN    = 3'd2;
  localparam logic [2:0] S_ENT_RD = 3'd3;
  localparam logic [2:0] S_ENT_WB = 3'd4;
  localparam logic [2:0] S_ORD    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;
  logic issue_q, issue_d;
  logic [SW-1:0] ix_q, ix_d;
  logic p1_v_q, p1_v_d, p1_last_q, p1_last_d, p1_wr_q, p1_wr_d;
  logic [SW-1:0] p1_pos_q, p1_pos_d;
  logic p2_v_q, p2_v_d, p2_last_q, p2_last_d, p2_wr_q, p2_wr_d;
  logic [SW-1:0] p2_slot_q, p2_slot_d;
  logic hit_q, hit_d, free_q, free_d;
  logic [SW-1:0] hit_slot_q, hit_slot_d, free_slot_q, free_slot_d, carry_q, carry_d;
  lbc_pkg::entry_t hit_ent_q, hit_ent_d;
  logic [ENTRIES-1:0] ord_wr_q, ord_wr_d, ent_wr_q, ent_wr_d;
  logic [1:0] op_q, op_d;
  logic [15:0] dev_q, dev_d;
  logic [31:0] blk_q, blk_d;
  logic [2:0] slot_q, slot_d;
  lbc_pkg::rsp_t resp_q, resp_d;

  logic ord_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata, ord_val, slot_idx;
  logic ent_we;
  logic [SW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_rdata;
  lbc_pkg::entry_t ent_wdata, ent_scan, ent_slot;
  logic tag_match, eligible, in_range;

  lbc_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  lbc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // unwritten order positions hold the reset order, unwritten entries read as zero
  assign ord_val  = p1_wr_q ? ord_rdata : (LAST - p1_pos_q);
  assign slot_idx = SW'(slot_q);
  assign ent_scan = p2_wr_q ? lbc_pkg::entry_t'(ent_rdata) : '0;
  assign ent_slot = ent_wr_q[slot_idx] ? lbc_pkg::entry_t'(ent_rdata) : '0;
  assign tag_match = (ent_scan.dev == dev_q) && (ent_scan.blk == blk_q);
  assign eligible  = (ent_scan.cnt == 8'd0) && !ent_scan.dirty;
  assign in_range  = 32'(req_i.slot_in) < 32'(ENTRIES);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = resp_q;

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    ix_d = ix_q;
    hit_d = hit_q;
    hit_slot_d = hit_slot_q;
    hit_ent_d = hit_ent_q;
    free_d = free_q;
    free_slot_d = free_slot_q;
    carry_d = carry_q;
    ord_wr_d = ord_wr_q;
    ent_wr_d = ent_wr_q;
    op_d = op_q;
    dev_d = dev_q;
    blk_d = blk_q;
    slot_d = slot_q;
    resp_d = resp_q;

    ord_we = 1'b0;
    ord_waddr = p1_pos_q;
    ord_wdata = carry_q;
    ord_raddr = ix_q;
    ent_we = 1'b0;
    ent_waddr = slot_idx;
    ent_wdata = ent_slot;
    ent_raddr = (state_q == S_SCAN) ? ord_val : slot_idx;

    // position read pipeline: order RAM, then entry RAM
    p1_v_d = issue_q;
    p1_pos_d = ix_q;
    p1_wr_d = ord_wr_q[ix_q];
    p1_last_d = (ix_q == LAST);
    if (issue_q) begin
      if (ix_q == LAST) begin
        issue_d = 1'b0;
      end else begin
        ix_d = ix_q + 1'b1;
      end
    end
    p2_v_d = p1_v_q && (state_q == S_SCAN);
    p2_last_d = p1_last_q;
    p2_slot_d = ord_val;
    p2_wr_d = ent_wr_q[ord_val];

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d = req_i.opcode;
          dev_d = req_i.device;
          blk_d = req_i.block_number;
          slot_d = req_i.slot_in;
          if (req_i.opcode == lbc_pkg::OP_GET) begin
            state_d = S_SCAN;
            ix_d = '0;
            issue_d = 1'b1;
            hit_d = 1'b0;
            free_d = 1'b0;
          end else if ((req_i.opcode == lbc_pkg::OP_WRITE ||
                        req_i.opcode == lbc_pkg::OP_RELEASE) && in_range) begin
            state_d = S_ENT_RD;
          end else begin
            resp_d = '{slot_out: req_i.slot_in, status: lbc_pkg::ST_ERROR,
                       need_disk_read: 1'b0, need_disk_write: 1'b0};
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (p2_v_q) begin
          if (tag_match && !hit_q) begin
            hit_d = 1'b1;
            hit_slot_d = p2_slot_q;
            hit_ent_d = ent_scan;
          end
          if (eligible) begin
            free_d = 1'b1;
            free_slot_d = p2_slot_q;
          end
          if (p2_last_q) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_d = S_RESP;
        if (hit_q) begin
          if (hit_ent_q.cnt == lbc_pkg::COUNT_LIMIT) begin
            resp_d = '{slot_out: 3'(hit_slot_q), status: lbc_pkg::ST_ERROR,
                       need_disk_read: 1'b0, need_disk_write: 1'b0};
          end else begin
            ent_we = 1'b1;
            ent_waddr = hit_slot_q;
            ent_wdata = '{dev: dev_q, blk: blk_q, cnt: hit_ent_q.cnt + 8'd1,
                          dirty: hit_ent_q.dirty, valid: 1'b1};
            resp_d = '{slot_out: 3'(hit_slot_q), status: lbc_pkg::ST_HIT,
                       need_disk_read: !hit_ent_q.valid, need_disk_write: 1'b0};
          end
        end else if (free_q) begin
          ent_we = 1'b1;
          ent_waddr = free_slot_q;
          ent_wdata = '{dev: dev_q, blk: blk_q, cnt: 8'd1, dirty: 1'b0, valid: 1'b1};
          resp_d = '{slot_out: 3'(free_slot_q), status: lbc_pkg::ST_ALLOC,
                     need_disk_read: 1'b1, need_disk_write: 1'b0};
        end else begin
          resp_d = '{slot_out: 3'd0, status: lbc_pkg::ST_NOBUF,
                     need_disk_read: 1'b0, need_disk_write: 1'b0};
        end
      end
      S_ENT_RD: begin
        state_d = S_ENT_WB;
      end
      S_ENT_WB: begin
        state_d = S_RESP;
        if (op_q == lbc_pkg::OP_WRITE) begin
          ent_we = 1'b1;
          ent_wdata = '{dev: ent_slot.dev, blk: ent_slot.blk, cnt: ent_slot.cnt,
                        dirty: 1'b1, valid: 1'b1};
          resp_d = '{slot_out: slot_q, status: lbc_pkg::ST_DONE,
                     need_disk_read: 1'b0, need_disk_write: 1'b1};
        end else if (ent_slot.cnt == 8'd0) begin
          resp_d = '{slot_out: slot_q, status: lbc_pkg::ST_ERROR,
                     need_disk_read: 1'b0, need_disk_write: 1'b0};
        end else begin
          ent_we = 1'b1;
          ent_wdata = '{dev: ent_slot.dev, blk: ent_slot.blk, cnt: ent_slot.cnt - 8'd1,
                        dirty: ent_slot.dirty, valid: ent_slot.valid};
          resp_d = '{slot_out: slot_q, status: lbc_pkg::ST_DONE,
                     need_disk_read: 1'b0, need_disk_write: 1'b0};
          if (ent_slot.cnt == 8'd1) begin
            state_d = S_ORD;
            ix_d = '0;
            issue_d = 1'b1;
            carry_d = slot_idx;
          end
        end
      end
      S_ORD: begin
        // shift positions down by one up to the released slot, slot goes in front
        if (p1_v_q) begin
          ord_we = 1'b1;
          ord_wr_d[p1_pos_q] = 1'b1;
          carry_d = ord_val;
          if (ord_val == slot_idx) begin
            issue_d = 1'b0;
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (rsp_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ent_we) begin
      ent_wr_d[ent_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
      ix_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      ord_wr_q <= '0;
      ent_wr_q <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      ix_q <= ix_d;
      p1_v_q <= p1_v_d;
      p2_v_q <= p2_v_d;
      hit_q <= hit_d;
      free_q <= free_d;
      ord_wr_q <= ord_wr_d;
      ent_wr_q <= ent_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_pos_q <= p1_pos_d;
    p1_wr_q <= p1_wr_d;
    p1_last_q <= p1_last_d;
    p2_last_q <= p2_last_d;
    p2_slot_q <= p2_slot_d;
    p2_wr_q <= p2_wr_d;
    hit_slot_q <= hit_slot_d;
    hit_ent_q <= hit_ent_d;
    free_slot_q <= free_slot_d;
    carry_q <= carry_d;
    op_q <= op_d;
    dev_q <= dev_d;
    blk_q <= blk_d;
    slot_q <= slot_d;
    resp_q <= resp_d;
  end
endmodule

// ===== rtl/lru_block_buffer_cache_top.sv =====
// LRU block buffer cache top level: sequencer plus response output register.
// Get scans the whole recency order; write and release work on the entry of one slot,
// and a release that drops the count to zero also rotates the recency order.
// One item at a time; the order-RAM scan sets the get time, one position a cycle.
// Reset (rst_ni low, async) empties the cache with no clearing pass: per-entry
// written flags make tags read as zero and the order read as its reset value.
module lru_block_buffer_cache_top #(
  parameter int unsigned ENTRIES = lbc_pkg::ENTRIES_DEFAULT
) (
  input logic       clk_i,
  input logic       rst_ni,
  lbc_req_if.sink   req_i,
  lbc_rsp_if.source rsp_o
);
  logic          seq_valid;
  lbc_pkg::rsp_t seq_rsp;
  logic          take;
  logic          out_valid_q;
  lbc_pkg::rsp_t out_q;

  lbc_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_valid_o (seq_valid),
    .rsp_o       (seq_rsp),
    .rsp_take_i  (take)
  );

  assign take = seq_valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= seq_rsp;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.slot_out        = out_q.slot_out;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.need_disk_read  = out_q.need_disk_read;
  assign rsp_o.need_disk_write = out_q.need_disk_write;
endmodule

// ===== rtl/lbc_checker.sv =====
// Port-level assertions for the buffer cache top, bound to it below.
// Depends on lbc_pkg and lru_block_buffer_cache_top.
module lbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  slot_out_i,
  input logic [2:0]  status_i,
  input logic        need_disk_read_i,
  input logic        need_disk_write_i
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response item dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable({slot_out_i, status_i, need_disk_read_i, need_disk_write_i}))
    else $error("response item changed while stalled");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i <= lbc_pkg::ST_DONE) &&
      (!need_disk_write_i || status_i == lbc_pkg::ST_DONE) &&
      (!need_disk_read_i || status_i == lbc_pkg::ST_HIT ||
       status_i == lbc_pkg::ST_ALLOC))
    else $error("status and disk flags disagree");

  a_nobuf_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == lbc_pkg::ST_NOBUF |-> slot_out_i == 3'd0)
    else $error("no-buffer result with nonzero slot");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous item in progress");
endmodule

bind lru_block_buffer_cache_top lbc_checker u_lbc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .slot_out_i        (rsp_o.slot_out),
  .status_i          (rsp_o.status),
  .need_disk_read_i  (rsp_o.need_disk_read),
  .need_disk_write_i (rsp_o.need_disk_write)
);
